FILE: rtl/core/mtsr_pkg.sv
// Shared types and codes for the multi-term substring row filter.
`default_nettype none
package mtsr_pkg;

    localparam logic [2:0] FUNC_NEW_TABLE   = 3'd0;
    localparam logic [2:0] FUNC_CLEAR_TERMS = 3'd1;
    localparam logic [2:0] FUNC_TERM_BYTE   = 3'd2;
    localparam logic [2:0] FUNC_END_TERM    = 3'd3;
    localparam logic [2:0] FUNC_ROW_BYTE    = 3'd4;
    localparam logic [2:0] FUNC_END_ROW     = 3'd5;

    localparam logic MODE_OR  = 1'b0;
    localparam logic MODE_AND = 1'b1;

    localparam logic [0:0] REG_MATCH_MODE = 1'b0;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
    } mtsr_in_t;

    typedef struct packed {
        logic [31:0] row_index;
        logic [31:0] match_count;
    } mtsr_out_t;

    // control handed from the sequencer to every term cell
    typedef struct packed {
        logic clr_terms;
        logic clr_found;
        logic wr_byte;
        logic row_byte;
        logic active;
    } mtsr_term_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/multi_term_substring_row_filter_unit.sv
// Top level of the multi-term substring row filter.
// Usage:
//  Requests arrive on in_valid/in_stall/in_data, one per cycle at most. A request
//  is a command code and a byte: new table, clear terms, term byte, end term,
//  row byte, end row. Term bytes load the term cell picked by the loaded-term
//  count; row bytes shift through a chain of window cells and every term cell
//  compares its stored bytes against the window in the same cycle.
//  An end row request that qualifies yields one result on out_valid/out_stall/
//  out_data in the cycle after: the row index and the running match count.
//  match_mode (APB, address 0): 0 any term (OR), 1 all terms (AND).
// Throughput: one request per cycle while in_stall is low, set by the combinational
//  window compare in the term cells.
// Stall: a result waits in the output register; requests keep flowing unless
//  that register is full and stalled, then in_stall is raised.
// Reset: no terms, empty window, row counter all ones, match count zero, OR.
`default_nettype none
module multi_term_substring_row_filter_unit
    import mtsr_pkg::*;
#(
    parameter int MAX_TERMS    = 8,
    parameter int MAX_TERM_LEN = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire mtsr_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output mtsr_out_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LW = $clog2(MAX_TERM_LEN + 1);
    localparam int TW = $clog2(MAX_TERMS + 1);

    logic                          in_acc;
    logic                          mode_reg;
    logic [TW-1:0]                 loaded_reg;
    logic [TW-1:0]                 loaded_next;
    logic [LW-1:0]                 row_len_reg;
    logic [LW-1:0]                 row_len_next;
    logic [31:0]                   cur_row_reg;
    logic [31:0]                   cur_row_next;
    logic [31:0]                   qual_reg;
    logic [31:0]                   qual_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    mtsr_out_t                     out_reg;
    mtsr_out_t                     out_next;
    logic [MAX_TERM_LEN-1:0][7:0]  win;
    logic [MAX_TERM_LEN-1:0][7:0]  win_next;
    logic [MAX_TERMS-1:0]          term_match;
    logic [MAX_TERMS-1:0]          active;
    logic                          qualifies;
    logic                          is_row_byte;
    logic                          row_clear;

    // APB register: only match_mode at address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MATCH_MODE) ? {31'b0, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OR;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_MATCH_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign in_stall    = out_valid_reg && out_stall;
    assign in_acc      = in_valid && !in_stall;
    assign is_row_byte = in_acc && (in_data.func == FUNC_ROW_BYTE);
    assign row_clear   = in_acc && ((in_data.func == FUNC_NEW_TABLE) ||
                                    (in_data.func == FUNC_END_ROW));

    // window as it stands after this row byte
    always_comb
    begin
        win_next[0] = in_data.data_byte;
        for (int k = 1; k < MAX_TERM_LEN; k++)
        begin
            win_next[k] = win[k-1];
        end
        row_len_next = (row_len_reg < LW'(MAX_TERM_LEN)) ? row_len_reg + 1'b1 : row_len_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TERM_LEN; g++)
        begin : g_win
            mtsr_win_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (is_row_byte),
                .clear (row_clear),
                .din   (win_next[g]),
                .dout  (win[g])
            );
        end

        for (g = 0; g < MAX_TERMS; g++)
        begin : g_term
            mtsr_term_ctl_t ctl;
            assign active[g]     = TW'(g) < loaded_reg;
            assign ctl.clr_terms = in_acc && (in_data.func == FUNC_CLEAR_TERMS);
            assign ctl.clr_found = row_clear || ctl.clr_terms;
            assign ctl.wr_byte   = in_acc && (in_data.func == FUNC_TERM_BYTE) &&
                                   (loaded_reg == TW'(g));
            assign ctl.row_byte  = is_row_byte;
            assign ctl.active    = active[g];
            mtsr_term_cell #(.MAX_TERM_LEN(MAX_TERM_LEN)) u_term (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .data_byte    (in_data.data_byte),
                .win_next     (win_next),
                .row_len_next (row_len_next),
                .term_ok      (term_match[g])
            );
        end
    endgenerate

    // AND passes with no terms; OR needs at least one loaded match
    assign qualifies = (mode_reg == MODE_AND) ? &(term_match | ~active)
                                              : |(term_match & active);

    always_comb
    begin
        loaded_next    = loaded_reg;
        cur_row_next   = cur_row_reg;
        qual_next      = qual_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (in_acc)
        begin
            case (in_data.func)
                FUNC_NEW_TABLE:
                begin
                    cur_row_next = '1;
                    qual_next    = '0;
                end
                FUNC_CLEAR_TERMS:
                begin
                    loaded_next = '0;
                end
                FUNC_END_TERM:
                begin
                    if (loaded_reg < TW'(MAX_TERMS))
                    begin
                        loaded_next = loaded_reg + 1'b1;
                    end
                end
                FUNC_END_ROW:
                begin
                    cur_row_next = cur_row_reg + 32'd1;
                    if (qualifies)
                    begin
                        qual_next            = qual_reg + 32'd1;
                        out_next.row_index   = cur_row_reg + 32'd1;
                        out_next.match_count = qual_reg + 32'd1;
                        out_valid_next       = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            row_len_reg   <= '0;
            cur_row_reg   <= '1;
            qual_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            cur_row_reg   <= cur_row_next;
            qual_reg      <= qual_next;
            out_valid_reg <= out_valid_next;
            if (row_clear)
            begin
                row_len_reg <= '0;
            end
            else if (is_row_byte)
            begin
                row_len_reg <= row_len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // term count never runs past the number of cells
    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= TW'(MAX_TERMS))
        else $error("term count beyond cell count");

    // a pending result always mirrors the live counters
    a_out_counters: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.match_count == qual_reg) &&
                          (out_reg.row_index == cur_row_reg))
        else $error("pending result out of step with counters");

    // a new table restarts the row and match counters
    a_new_table: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_data.func == FUNC_NEW_TABLE) |=>
            (cur_row_reg == '1) && (qual_reg == '0) && !out_valid_reg)
        else $error("new table did not restart counters");

endmodule
`default_nettype wire

FILE: rtl/core/mtsr_win_cell.sv
// One byte stage of the row window shift line.
`default_nettype none
module mtsr_win_cell
    import mtsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic       clear,
    input  wire logic [7:0] din,
    output logic      [7:0] dout
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = '0;
        end
        else if (shift)
        begin
            byte_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule
`default_nettype wire

FILE: rtl/core/mtsr_term_cell.sv
// One search term: its bytes, length, overflow flag and found bit.
`default_nettype none
module mtsr_term_cell
    import mtsr_pkg::*;
#(
    parameter int MAX_TERM_LEN = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mtsr_term_ctl_t                     ctl,
    input  wire logic [7:0]                         data_byte,
    input  wire logic [MAX_TERM_LEN-1:0][7:0]       win_next,
    input  wire logic [$clog2(MAX_TERM_LEN+1)-1:0]  row_len_next,
    output logic                                    term_ok
);

    localparam int LW = $clog2(MAX_TERM_LEN + 1);

    // newest term byte sits at index 0, lining up with the window
    logic [MAX_TERM_LEN-1:0][7:0] tbytes_reg;
    logic [MAX_TERM_LEN-1:0][7:0] tbytes_next;
    logic [LW-1:0]                len_reg;
    logic [LW-1:0]                len_next;
    logic                         ovl_reg;
    logic                         ovl_next;
    logic                         found_reg;
    logic                         found_next;
    logic [MAX_TERM_LEN-1:0]      pos_ok;
    logic                         hit;

    always_comb
    begin
        for (int k = 0; k < MAX_TERM_LEN; k++)
        begin
            pos_ok[k] = (LW'(k) >= len_reg) || (tbytes_reg[k] == win_next[k]);
        end
        hit = !ovl_reg && (len_reg != '0) && (len_reg <= row_len_next) && (&pos_ok);
    end

    always_comb
    begin
        tbytes_next = tbytes_reg;
        len_next    = len_reg;
        ovl_next    = ovl_reg;
        found_next  = found_reg;
        if (ctl.clr_terms)
        begin
            len_next   = '0;
            ovl_next   = 1'b0;
            found_next = 1'b0;
        end
        else if (ctl.wr_byte)
        begin
            if (len_reg < LW'(MAX_TERM_LEN))
            begin
                tbytes_next = {tbytes_reg[MAX_TERM_LEN-2:0], data_byte};
                len_next    = len_reg + 1'b1;
            end
            else
            begin
                ovl_next = 1'b1;
            end
        end
        if (ctl.clr_found)
        begin
            found_next = 1'b0;
        end
        else if (ctl.row_byte && ctl.active && hit)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        tbytes_reg <= tbytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovl_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            ovl_reg   <= ovl_next;
            found_reg <= found_next;
        end
    end

    assign term_ok = !ovl_reg && ((len_reg == '0) || found_reg);

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the multi-term substring row filter: random and directed requests, self-checking.
`default_nettype none
module tb;
    import mtsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTERMS  = 8;
    localparam int TERMLEN = 32;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    mtsr_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    mtsr_out_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multi_term_substring_row_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state, a mirror of the filter's own registers
    // ------------------------------------------------------------------
    logic [7:0]  pat_bytes [NTERMS][TERMLEN];
    int unsigned pat_len   [NTERMS];
    bit          pat_long  [NTERMS];
    int unsigned pat_count;
    logic [7:0]  window    [TERMLEN];
    int unsigned window_fill;
    bit          pat_seen  [NTERMS];
    logic [31:0] row_ctr;
    logic [31:0] hit_ctr;
    logic        mode_and;

    mtsr_out_t   hits_due [$];     // rows expected out of the filter
    mtsr_in_t    pending  [$];     // requests waiting for the driver
    int          gap_len  [$];     // idle cycles before each request

    int unsigned errors;
    int unsigned mismatches;

    function automatic void forget_row();
        for (int i = 0; i < TERMLEN; i++)
            window[i] = 8'h00;
        for (int t = 0; t < NTERMS; t++)
            pat_seen[t] = 1'b0;
        window_fill = 0;
    endfunction

    function automatic void forget_terms();
        for (int t = 0; t < NTERMS; t++)
        begin
            pat_len[t]  = 0;
            pat_long[t] = 1'b0;
            pat_seen[t] = 1'b0;
        end
        pat_count = 0;
    endfunction

    // a term hits when the newest bytes of the window spell it out
    function automatic bit window_holds(int t);
        int unsigned n;
        n = pat_len[t];
        if (pat_long[t] || n == 0 || n > window_fill)
            return 1'b0;
        for (int j = 0; j < n; j++)
            if (pat_bytes[t][j] != window[n - 1 - j])
                return 1'b0;
        return 1'b1;
    endfunction

    // advance the filter mirror by one accepted request
    function automatic void filter_step(mtsr_in_t req);
        bit       pass;
        bit       ok;
        mtsr_out_t r;
        case (req.func)
            FUNC_NEW_TABLE:
            begin
                row_ctr = '1;
                hit_ctr = '0;
                forget_row();
            end
            FUNC_CLEAR_TERMS: forget_terms();
            FUNC_TERM_BYTE:
            begin
                if (pat_count < NTERMS)
                begin
                    if (pat_len[pat_count] < TERMLEN)
                    begin
                        pat_bytes[pat_count][pat_len[pat_count]] = req.data_byte;
                        pat_len[pat_count]++;
                    end
                    else
                        pat_long[pat_count] = 1'b1;
                end
            end
            FUNC_END_TERM:
            begin
                if (pat_count < NTERMS)
                    pat_count++;
            end
            FUNC_ROW_BYTE:
            begin
                for (int i = TERMLEN - 1; i > 0; i--)
                    window[i] = window[i - 1];
                window[0] = req.data_byte;
                if (window_fill < TERMLEN)
                    window_fill++;
                for (int t = 0; t < pat_count; t++)
                    if (window_holds(t))
                        pat_seen[t] = 1'b1;
            end
            FUNC_END_ROW:
            begin
                row_ctr++;
                pass = (mode_and == MODE_AND);
                for (int t = 0; t < pat_count; t++)
                begin
                    ok = !pat_long[t] && (pat_len[t] == 0 || pat_seen[t]);
                    if (mode_and == MODE_AND)
                        pass = pass && ok;
                    else
                        pass = pass || ok;
                end
                forget_row();
                if (pass)
                begin
                    hit_ctr++;
                    r.row_index   = row_ctr;
                    r.match_count = hit_ctr;
                    hits_due.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    int unsigned src_gap_max;      // 0 disables sender idling
    bit          sender_pause;     // driver holds off until all rows are back

    function automatic void queue_req(logic [2:0] f, logic [7:0] b);
        mtsr_in_t q;
        q.func      = f;
        q.data_byte = b;
        pending.push_back(q);
        gap_len.push_back(src_gap_max == 0 ? 0 : $urandom_range(0, src_gap_max));
    endfunction

    // small alphabet so terms occur in rows often
    function automatic logic [7:0] text_byte();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(97, 100));
    endfunction

    function automatic void queue_term(int n);
        for (int i = 0; i < n; i++)
            queue_req(FUNC_TERM_BYTE, text_byte());
        queue_req(FUNC_END_TERM, 8'($urandom));
    endfunction

    function automatic void queue_row(int n);
        for (int i = 0; i < n; i++)
            queue_req(FUNC_ROW_BYTE, text_byte());
        queue_req(FUNC_END_ROW, 8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Driver: one request from the queue at a time, random idle gaps
    // ------------------------------------------------------------------
    int unsigned idle_left;
    int unsigned accepted;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                filter_step(in_data);
                accepted <= accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                // slot free: either load the next request or idle
                if (idle_left != 0)
                begin
                    in_valid  <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (pending.size() != 0 && !(sender_pause && hits_due.size() != 0))
                begin
                    if (gap_len[0] != 0)
                    begin
                        in_valid  <= 1'b0;
                        idle_left <= gap_len[0] - 1;
                        gap_len[0] = 0;
                    end
                    else
                    begin
                        in_valid <= 1'b1;
                        in_data  <= pending.pop_front();
                        void'(gap_len.pop_front());
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and receiver stall
    // ------------------------------------------------------------------
    int unsigned sink_gap_max;
    int unsigned sink_wait;
    logic        hold_on = 1'b0;   // long receiver hold-off, timed in its own process

    always @(posedge clk or negedge rst_n)
    begin
        mtsr_out_t   want;
        int unsigned wait_draw;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_wait <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hits_due.size() == 0)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected row: index %0d count %0d",
                                 out_data.row_index, out_data.match_count);
                    mismatches++;
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (out_data.row_index !== want.row_index ||
                        out_data.match_count !== want.match_count)
                    begin
                        errors++;
                        if (mismatches < 10)
                            $display("row mismatch: expected index %0d count %0d, got %0d %0d",
                                     want.row_index, want.match_count,
                                     out_data.row_index, out_data.match_count);
                        mismatches++;
                    end
                end
            end
            if (hold_on)
            begin
                out_stall <= 1'b1;
            end
            else if (sink_wait != 0)
            begin
                sink_wait <= sink_wait - 1;
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall && sink_gap_max != 0)
            begin
                // draw the wait for the next result
                wait_draw = $urandom_range(0, sink_gap_max);
                sink_wait <= (wait_draw == 0) ? 0 : wait_draw - 1;
                out_stall <= (wait_draw != 0);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes, only with the filter idle
    // ------------------------------------------------------------------
    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_and = value[0];
        @(posedge clk);
        // read back the register just written
        if (prdata !== {31'b0, value[0]})
        begin
            errors++;
            if (mismatches < 10)
                $display("register readback: expected %0h, got %0h",
                         {31'b0, value[0]}, prdata);
            mismatches++;
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || in_valid || hits_due.size() != 0)
            @(posedge clk);
        // margin for the output register and for an end row that gave nothing
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed part: every func code, empty, overlong and excess terms
    // ------------------------------------------------------------------
    task automatic run_directed();
        src_gap_max = 0;
        queue_req(FUNC_END_ROW, 8'h00);          // no terms: OR rejects
        queue_req(FUNC_TERM_BYTE, 8'hFF);
        queue_req(FUNC_TERM_BYTE, 8'h00);
        queue_req(FUNC_END_TERM, 8'h00);
        queue_req(FUNC_ROW_BYTE, 8'h00);         // row shorter than the term
        queue_req(FUNC_END_ROW, 8'h00);
        queue_req(FUNC_ROW_BYTE, 8'hFF);
        queue_req(FUNC_ROW_BYTE, 8'h00);
        queue_req(FUNC_END_ROW, 8'hFF);          // match
        queue_req(3'd6, 8'hAA);                  // unused codes
        queue_req(3'd7, 8'h55);
        queue_req(FUNC_END_TERM, 8'h00);         // empty term
        queue_req(FUNC_END_ROW, 8'h00);
        queue_req(FUNC_NEW_TABLE, 8'h00);
        queue_req(FUNC_END_ROW, 8'h00);
        queue_req(FUNC_CLEAR_TERMS, 8'h00);
        queue_term(34);                          // overlong
        queue_req(FUNC_END_ROW, 8'h00);
        for (int t = 0; t < 9; t++)              // too many terms
            queue_term($urandom_range(0, 1));
        queue_row(3);
        queue_req(FUNC_CLEAR_TERMS, 8'h00);
    endtask

    // well-formed traffic: a term set then rows, with some noise
    task automatic run_random(int unsigned n_items);
        int unsigned start;
        int k;
        start = pending.size() + accepted;
        while (pending.size() + accepted < start + n_items)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                queue_req(FUNC_CLEAR_TERMS, 8'($urandom));
            else if (k == 1)
                queue_req(FUNC_NEW_TABLE, 8'($urandom));
            else if (k == 2)
                queue_req(3'($urandom_range(0, 7)), 8'($urandom));
            else if (k < 6 && pat_count < NTERMS)
                queue_term($urandom_range(0, 19) == 0 ? $urandom_range(30, 36)
                                                      : $urandom_range(0, 3));
            else if (k == 6)
                queue_row($urandom_range(30, 40));
            else
                queue_row($urandom_range(0, 10));
            // predictor term count runs behind the queue, so let the queue drain now and then
            if (pending.size() > 40)
                while (pending.size() > 8)
                    @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        errors       = 0;
        mismatches   = 0;
        accepted     = 0;
        sink_gap_max = 0;
        src_gap_max  = 0;
        sender_pause = 1'b0;
        mode_and     = MODE_OR;
        row_ctr      = '1;
        hit_ctr      = '0;
        forget_terms();
        forget_row();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        apb_write(3'(REG_MATCH_MODE) << 2, 32'(MODE_OR));
        run_directed();
        drain();
        apb_write(3'(REG_MATCH_MODE) << 2, 32'(MODE_AND));
        run_directed();
        drain();

        // random phases: OR and AND in turn, first without idling, then with it
        for (int ph = 0; ph < 4; ph++)
        begin
            apb_write(3'(REG_MATCH_MODE) << 2, 32'(ph[0]));
            src_gap_max  = (ph < 2) ? 0 : 19;
            sink_gap_max = (ph < 2) ? 0 : 19;
            if (ph == 1)
            begin
                // receiver holds off in its own process; fills the output register
                fork
                    begin
                        hold_on <= 1'b1;
                        repeat (300) @(posedge clk);
                        hold_on <= 1'b0;
                    end
                join_none
            end
            run_random(300);
            if (ph == 2)
            begin
                // sender waits for every outstanding row
                sender_pause = 1'b1;
                run_random(20);
                sender_pause = 1'b0;
            end
            drain();
        end

        if (errors == 0 && hits_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
